>>> rtl/poisson_disk_grid_acceptor_assert.svh
// Assertion macros shared by the grid acceptor RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef POISSON_DISK_GRID_ACCEPTOR_ASSERT_SVH
`define POISSON_DISK_GRID_ACCEPTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PDGA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PDGA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDGA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PDGA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/pdga_pkg.sv
// Package of the Poisson disk grid acceptor: sizes, codes and types.
// Used by the top level; depends on nothing.
package pdga_pkg;

    localparam int GRID_COLS       = 64;
    localparam int GRID_ROWS       = 64;
    localparam int COORD_FRAC_BITS = 8;
    localparam int NEIGHBOUR_REACH = 2;

    localparam int COORD_W  = 24;
    localparam int COL_W    = $clog2(GRID_COLS);
    localparam int ROW_W    = $clog2(GRID_ROWS);
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int DEPTH    = GRID_COLS * GRID_ROWS;
    localparam int CELL_W   = 1 + 2 * COORD_W;
    localparam int SPAN     = 2 * NEIGHBOUR_REACH + 1;
    localparam int SPAN_W   = $clog2(SPAN);
    localparam int DIM_W    = 7;
    localparam int CNT_W    = $clog2(COORD_W + 1);
    localparam int DRAIN_CYC = 3;

    localparam logic [COORD_W-1:0] D_ONE = COORD_W'(1);

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_OUTSIDE = 2'd1,
        STAT_CLOSE   = 2'd2,
        STAT_CLEARED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_DIST   = 3'd4,
        REG_COLS   = 3'd5,
        REG_ROWS   = 3'd6,
        REG_NONE   = 3'd7
    } t_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_DIVFIN,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    localparam logic OP_CLEAR = 1'b0;

endpackage

>>> rtl/pdga_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; instanced for the background grid.
module pdga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/poisson_disk_grid_acceptor.sv
// Sequence: an accepted candidate passes 24 divider steps, a rounding step, 25 cell
// reads and a drain before its result; an outside one goes straight to the result.
// Throughput: one transaction at a time; the radix-2 cell divider and the single grid
// read port bound the rate. A clear sweeps every grid cell before its result.
// Reset is synchronous and active low; after reset a clearing pass over all 4096
// cells sweeps the grid RAM, during which no transaction is taken.
`include "poisson_disk_grid_acceptor_assert.svh"
module poisson_disk_grid_acceptor
    import pdga_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [COORD_W-1:0]  i_cand_x,
    input  logic [COORD_W-1:0]  i_cand_y,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [5:0]          o_cell_col,
    output logic [5:0]          o_cell_row,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [15:0]        r_left, r_top, r_width, r_height;
    logic [COORD_W-1:0] r_dist;
    logic [DIM_W-1:0]   r_gcols, r_grows;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_clr_reply;
    logic               r_op, r_inside;
    logic [COORD_W-1:0] r_x, r_y, r_dd;
    logic [2*COORD_W-1:0] r_d2;
    logic [COORD_W-1:0] r_nx, r_ny, r_qx, r_qy, r_remx, r_remy;
    logic [CNT_W-1:0]   r_div_cnt;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [SPAN_W-1:0]  r_di, r_dj;
    logic [1:0]         r_drain;
    logic               r_s1_vld, r_s2_vld, r_s3_vld, r_close;
    logic [COORD_W-1:0] r_dx, r_dy;
    logic [2*COORD_W-1:0] r_sqx, r_sqy;
    logic               r_o_valid;
    t_status            r_o_status;
    logic [5:0]         r_o_col, r_o_row;

    logic [DIM_W-1:0]   cols_c, rows_c;
    logic [COORD_W-1:0] low_x, low_y;
    logic [COORD_W:0]   high_x, high_y;
    logic               in_acc, in_area, out_free, cfg_wr;
    logic [COORD_W:0]   shx, shy;
    logic               gex, gey;
    logic [COORD_W:0]   ceil_x, ceil_y;
    logic [DIM_W-1:0]   rr, cc;
    logic               inb;
    logic [ADDR_W-1:0]  raddr, waddr;
    logic [CELL_W-1:0]  rdata, wdata;
    logic               we;
    logic [2*COORD_W:0] dsum;
    t_status            fin_status;
    t_reg               reg_sel;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign reg_sel = t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= 16'd640;
            r_height <= 16'd640;
            r_dist   <= 24'd2560;
            r_gcols  <= 7'd64;
            r_grows  <= 7'd64;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_LEFT:   r_left   <= pwdata[15:0];
                REG_TOP:    r_top    <= pwdata[15:0];
                REG_WIDTH:  r_width  <= pwdata[15:0];
                REG_HEIGHT: r_height <= pwdata[15:0];
                REG_DIST:   r_dist   <= pwdata[COORD_W-1:0];
                REG_COLS:   r_gcols  <= pwdata[DIM_W-1:0];
                REG_ROWS:   r_grows  <= pwdata[DIM_W-1:0];
                REG_NONE: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_LEFT:   prdata = {16'd0, r_left};
            REG_TOP:    prdata = {16'd0, r_top};
            REG_WIDTH:  prdata = {16'd0, r_width};
            REG_HEIGHT: prdata = {16'd0, r_height};
            REG_DIST:   prdata = {8'd0, r_dist};
            REG_COLS:   prdata = {25'd0, r_gcols};
            REG_ROWS:   prdata = {25'd0, r_grows};
            REG_NONE:   prdata = '0;
        endcase
    end

    assign cols_c = (r_gcols == '0) ? DIM_W'(1) :
                    (r_gcols > DIM_W'(GRID_COLS)) ? DIM_W'(GRID_COLS) : r_gcols;
    assign rows_c = (r_grows == '0) ? DIM_W'(1) :
                    (r_grows > DIM_W'(GRID_ROWS)) ? DIM_W'(GRID_ROWS) : r_grows;

    assign low_x  = {r_left, COORD_FRAC_BITS'(0)};
    assign low_y  = {r_top, COORD_FRAC_BITS'(0)};
    assign high_x = {({1'b0, r_left} + {1'b0, r_width}), COORD_FRAC_BITS'(0)};
    assign high_y = {({1'b0, r_top} + {1'b0, r_height}), COORD_FRAC_BITS'(0)};
    assign in_area = (i_cand_x >= low_x) && ({1'b0, i_cand_x} < high_x) &&
                     (i_cand_y >= low_y) && ({1'b0, i_cand_y} < high_y);

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_o_valid || !i_out_stall;

    assign shx = {r_remx, r_nx[COORD_W-1]};
    assign shy = {r_remy, r_ny[COORD_W-1]};
    assign gex = (shx >= {1'b0, r_dd});
    assign gey = (shy >= {1'b0, r_dd});
    assign ceil_x = {1'b0, r_qx} + {{COORD_W{1'b0}}, (r_remx != '0)};
    assign ceil_y = {1'b0, r_qy} + {{COORD_W{1'b0}}, (r_remy != '0)};

    assign rr  = DIM_W'(r_row) + DIM_W'(r_di);
    assign cc  = DIM_W'(r_col) + DIM_W'(r_dj);
    assign inb = (rr >= DIM_W'(NEIGHBOUR_REACH)) &&
                 ((rr - DIM_W'(NEIGHBOUR_REACH)) < rows_c) &&
                 (cc >= DIM_W'(NEIGHBOUR_REACH)) &&
                 ((cc - DIM_W'(NEIGHBOUR_REACH)) < cols_c);
    assign raddr = {ROW_W'(rr - DIM_W'(NEIGHBOUR_REACH)),
                    COL_W'(cc - DIM_W'(NEIGHBOUR_REACH))};

    assign dsum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_comb begin
        priority if (r_op == OP_CLEAR) begin
            fin_status = STAT_CLEARED;
        end else if (!r_inside) begin
            fin_status = STAT_OUTSIDE;
        end else if (r_close) begin
            fin_status = STAT_CLOSE;
        end else begin
            fin_status = STAT_OK;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_clr_addr;
        wdata = '0;
        if (r_state == ST_CLEAR) begin
            we = 1'b1;
        end else if (r_state == ST_OUT && out_free && fin_status == STAT_OK) begin
            we    = 1'b1;
            waddr = {r_row, r_col};
            wdata = {1'b1, r_x, r_y};
        end
    end

    pdga_ram #(
        .WIDTH(CELL_W),
        .DEPTH(DEPTH)
    ) u_grid (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = r_clr_reply ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    priority if (i_operation == OP_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (!in_area) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (r_div_cnt == CNT_W'(COORD_W - 1)) begin
                    n_state = ST_DIVFIN;
                end
            end
            ST_DIVFIN: n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_di == SPAN_W'(SPAN - 1) && r_dj == SPAN_W'(SPAN - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain == 2'(DRAIN_CYC - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_o_valid   <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_close     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= (r_state == ST_SCAN) && inb;
            r_s2_vld <= r_s1_vld && rdata[CELL_W-1];
            r_s3_vld <= r_s2_vld;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (in_acc) begin
                r_clr_reply <= 1'b1;
                r_close     <= 1'b0;
            end else if (r_s3_vld && (dsum < {1'b0, r_d2})) begin
                r_close <= 1'b1;
            end
            if (r_state == ST_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d2 <= r_dd * r_dd;
        r_dx <= (rdata[2*COORD_W-1:COORD_W] >= r_x) ?
                rdata[2*COORD_W-1:COORD_W] - r_x : r_x - rdata[2*COORD_W-1:COORD_W];
        r_dy <= (rdata[COORD_W-1:0] >= r_y) ?
                rdata[COORD_W-1:0] - r_y : r_y - rdata[COORD_W-1:0];
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
        if (in_acc) begin
            r_op      <= i_operation;
            r_inside  <= in_area;
            r_x       <= i_cand_x;
            r_y       <= i_cand_y;
            r_dd      <= (r_dist == '0) ? D_ONE : r_dist;
            r_nx      <= i_cand_x - low_x;
            r_ny      <= i_cand_y - low_y;
            r_remx    <= '0;
            r_remy    <= '0;
            r_div_cnt <= '0;
            r_drain   <= '0;
        end
        if (r_state == ST_DIV) begin
            r_nx      <= {r_nx[COORD_W-2:0], 1'b0};
            r_ny      <= {r_ny[COORD_W-2:0], 1'b0};
            r_qx      <= {r_qx[COORD_W-2:0], gex};
            r_qy      <= {r_qy[COORD_W-2:0], gey};
            r_remx    <= gex ? COORD_W'(shx - {1'b0, r_dd}) : COORD_W'(shx);
            r_remy    <= gey ? COORD_W'(shy - {1'b0, r_dd}) : COORD_W'(shy);
            r_div_cnt <= r_div_cnt + CNT_W'(1);
        end
        if (r_state == ST_DIVFIN) begin
            r_col <= (ceil_x > (COORD_W + 1)'(cols_c - DIM_W'(1))) ?
                     COL_W'(cols_c - DIM_W'(1)) : COL_W'(ceil_x);
            r_row <= (ceil_y > (COORD_W + 1)'(rows_c - DIM_W'(1))) ?
                     ROW_W'(rows_c - DIM_W'(1)) : ROW_W'(ceil_y);
            r_di  <= '0;
            r_dj  <= '0;
        end
        if (r_state == ST_SCAN) begin
            if (r_dj == SPAN_W'(SPAN - 1)) begin
                r_dj <= '0;
                r_di <= r_di + SPAN_W'(1);
            end else begin
                r_dj <= r_dj + SPAN_W'(1);
            end
        end
        if (r_state == ST_DRAIN) begin
            r_drain <= r_drain + 2'd1;
        end
        if (r_state == ST_OUT && out_free) begin
            r_o_status <= fin_status;
            r_o_col    <= (fin_status == STAT_OK || fin_status == STAT_CLOSE) ?
                          6'(r_col) : 6'd0;
            r_o_row    <= (fin_status == STAT_OK || fin_status == STAT_CLOSE) ?
                          6'(r_row) : 6'd0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_cell_col  = r_o_col;
    assign o_cell_row  = r_o_row;

    `PDGA_ASSERT(a_out_from_out_state, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state) == ST_OUT, "result raised outside the result state")
    `PDGA_ASSERT(a_outside_zero_cell, i_clk, i_rst_n, (o_out_valid && (o_status == STAT_OUTSIDE || o_status == STAT_CLEARED)) |-> (o_cell_col == 6'd0 && o_cell_row == 6'd0), "rejected or clear result carries a cell")
    `PDGA_ASSERT(a_scan_in_grid, i_clk, i_rst_n, (r_state == ST_SCAN && inb) |-> (DIM_W'(raddr[ADDR_W-1:COL_W]) < rows_c && DIM_W'(raddr[COL_W-1:0]) < cols_c), "scan reads beyond the grid in use")
    `PDGA_ASSERT(a_insert_not_in_clear, i_clk, i_rst_n, (we && r_state != ST_CLEAR) |-> (r_op != OP_CLEAR && r_inside && !r_close), "insert written for a rejected transaction")

endmodule
